>>> rtl/core/wpea_pkg.sv
// wpea_pkg: shared widths, register codes and control types of the waveform averager
// depends on nothing; imported by every other file of the block but wpea_ram
package wpea_pkg;

    // field widths
    localparam int POS_W      = 10;
    localparam int SMP_W      = 8;
    localparam int ACC_W      = 16;
    localparam int CNT_W      = 10;
    localparam int SHIFT_W    = 4;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // frame counter ceiling
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // parameter defaults
    localparam int POINTS_DEF   = 1024;
    localparam int CHANNELS_DEF = 2;

    // register reset values
    localparam logic [SHIFT_W-1:0] AVG_SHIFT_RST = SHIFT_W'(1);
    localparam logic [CNT_W-1:0]   WARMUP_RST    = CNT_W'(2);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_SHIFT = 1'b0,
        CFG_WARMUP    = 1'b1
    } t_cfg_idx;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // per-channel counter status for the item at the input
    typedef struct packed {
        logic ch_ok;
        logic seed;
        logic past_warmup;
    } t_cnt_info;

    // control bits that travel with an item into the update stage
    typedef struct packed {
        logic cmd;
        logic point_ok;
        logic seed;
        logic avg_en;
    } t_item_ctl;

endpackage

>>> rtl/core/wpea_in_if.sv
// wpea_in_if: input item channel (valid, ready, sample item fields)
// depends on wpea_pkg
interface wpea_in_if import wpea_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic             channel;
    logic [POS_W-1:0] position;
    logic [SMP_W-1:0] sample;
    logic             frame_end;

    modport source (output valid, cmd, channel, position, sample, frame_end, input ready);
    modport sink   (input valid, cmd, channel, position, sample, frame_end, output ready);
endinterface

>>> rtl/core/wpea_out_if.sv
// wpea_out_if: result item channel (valid, ready, averaged sample)
// depends on wpea_pkg
interface wpea_out_if import wpea_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample_out;
    logic             averaged;

    modport source (output valid, sample_out, averaged, input ready);
    modport sink   (input valid, sample_out, averaged, output ready);
endinterface

>>> rtl/core/wpea_ram.sv
// wpea_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module wpea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/wpea_frame_ctr.sv
// wpea_frame_ctr: per-channel saturating frame counters and warm-up status
// depends on wpea_pkg
module wpea_frame_ctr import wpea_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_cmd,
    input  logic             i_channel,
    input  logic             i_frame_end,
    input  logic [CNT_W-1:0] i_warmup,
    output t_cnt_info        o_info
);

    logic [CNT_W-1:0] r_count [CHANNELS];
    logic [CNT_W-1:0] n_count [CHANNELS];
    logic [CNT_W-1:0] sel_count;
    logic             ch_ok;

    // select the counter of the item's channel
    always_comb begin
        sel_count = '0;
        ch_ok     = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (32'(i_channel) == c) begin
                sel_count = r_count[c];
                ch_ok     = 1'b1;
            end
        end
    end

    assign o_info.ch_ok       = ch_ok;
    assign o_info.seed        = (sel_count == '0);
    assign o_info.past_warmup = (sel_count > i_warmup);

    // next counts: clear all, or advance the item's channel on frame end
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_count[c] = r_count[c];
            if (i_accept) begin
                if (i_cmd == CMD_CLEAR) begin
                    n_count[c] = '0;
                end else if (32'(i_channel) == c && i_frame_end &&
                             r_count[c] != COUNT_MAX) begin
                    n_count[c] = r_count[c] + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c] <= '0;
            end
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/wpea_update.sv
// wpea_update: read-modify-write stage with write forwarding, plus output register
// depends on wpea_pkg, wpea_out_if
module wpea_update import wpea_pkg::*; #(
    parameter int AW = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_item_ctl          i_ctl,
    input  logic [SMP_W-1:0]   i_sample,
    input  logic [AW-1:0]      i_addr,
    input  logic [ACC_W-1:0]   i_rdata,
    input  logic [SHIFT_W-1:0] i_avg_shift,
    output logic               o_in_ready,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [ACC_W-1:0]   o_wdata,
    wpea_out_if.source         o_out
);

    // update stage registers
    logic               r_s1_valid;
    t_item_ctl          r_s1_ctl;
    logic [SMP_W-1:0]   r_s1_sample;
    logic [AW-1:0]      r_s1_addr;

    // last memory write, for an item whose read raced it
    logic               r_fwd_valid;
    logic [AW-1:0]      r_fwd_addr;
    logic [ACC_W-1:0]   r_fwd_data;

    // output register
    logic               r_out_valid;
    logic [SMP_W-1:0]   r_out_sample;
    logic               r_out_avg;

    logic               advance;
    logic [ACC_W-1:0]   base;
    logic [ACC_W-1:0]   acc;
    logic [SMP_W-1:0]   result;
    logic               avg_bit;

    assign advance    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign o_in_ready = !r_s1_valid || advance;

    // accumulator update
    always_comb begin
        if (r_s1_ctl.seed) begin
            base = ACC_W'(r_s1_sample);
        end else if (r_fwd_valid && r_fwd_addr == r_s1_addr) begin
            base = r_fwd_data;
        end else begin
            base = i_rdata;
        end
        acc = base - (base >> i_avg_shift) + ACC_W'(r_s1_sample);
        if (r_s1_ctl.cmd == CMD_CLEAR) begin
            result  = '0;
            avg_bit = 1'b0;
        end else if (r_s1_ctl.point_ok && r_s1_ctl.avg_en) begin
            result  = SMP_W'(acc >> i_avg_shift);
            avg_bit = 1'b1;
        end else begin
            result  = r_s1_sample;
            avg_bit = 1'b0;
        end
    end

    assign o_we    = advance && r_s1_ctl.cmd == CMD_SAMPLE && r_s1_ctl.point_ok;
    assign o_waddr = r_s1_addr;
    assign o_wdata = acc;

    // stage and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_accept;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_we) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctl    <= i_ctl;
            r_s1_sample <= i_sample;
            r_s1_addr   <= i_addr;
        end
        if (o_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= acc;
        end
        if (advance) begin
            r_out_sample <= result;
            r_out_avg    <= avg_bit;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.averaged   = r_out_avg;

endmodule

>>> rtl/core/waveform_point_exponential_averager.sv
// waveform_point_exponential_averager: top level of the per-point exponential averager
// depends on wpea_pkg, wpea_in_if, wpea_out_if, wpea_ram, wpea_frame_ctr, wpea_update
//
//   port      dir  flow         carries
//   i_in      in   valid/ready  cmd, channel, position, sample, frame_end
//   o_out     out  valid/ready  sample_out, averaged
//   i_cfg_*   in   write only   avg_shift (index 0), warmup_frames (index 1)
//
// one item per clock while results are taken; the accumulator memory read is issued
// at accept, and the write and the output register load both happen when the update stage advances
// an item that hits the entry written in the same cycle takes forwarded data
// reset zeroes frame counters and sets the registers; accumulators are not
// cleared, they are seeded on a channel's first frame, so no clearing pass
// a stalled output holds the update stage and its memory read; input ready
// then drops until the result is taken
module waveform_point_exponential_averager import wpea_pkg::*; #(
    parameter int POINTS   = POINTS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wpea_in_if.sink               i_in,
    wpea_out_if.source            o_out
);

    localparam int DEPTH = CHANNELS * POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SHIFT_W-1:0] r_avg_shift;
    logic [CNT_W-1:0]   r_warmup;

    logic               in_accept;
    logic               in_ready;
    t_cnt_info          cnt_info;
    t_item_ctl          item_ctl;
    logic [AW-1:0]      rd_addr;
    logic [ACC_W-1:0]   rd_data;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ACC_W-1:0]   ram_wdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_shift <= AVG_SHIFT_RST;
            r_warmup    <= WARMUP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_AVG_SHIFT: r_avg_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_WARMUP:    r_warmup    <= i_cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    // frame counters
    wpea_frame_ctr #(
        .CHANNELS (CHANNELS)
    ) u_frame_ctr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_cmd       (i_in.cmd),
        .i_channel   (i_in.channel),
        .i_frame_end (i_in.frame_end),
        .i_warmup    (r_warmup),
        .o_info      (cnt_info)
    );

    // item control and accumulator address
    assign item_ctl.cmd      = i_in.cmd;
    assign item_ctl.point_ok = cnt_info.ch_ok && (32'(i_in.position) < POINTS);
    assign item_ctl.seed     = cnt_info.seed;
    assign item_ctl.avg_en   = cnt_info.past_warmup;

    assign rd_addr = (i_in.channel ? AW'(POINTS) : AW'(0)) + AW'(i_in.position);

    // accumulator memory
    wpea_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // read-modify-write and output
    wpea_update #(
        .AW (AW)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_ctl       (item_ctl),
        .i_sample    (i_in.sample),
        .i_addr      (rd_addr),
        .i_rdata     (rd_data),
        .i_avg_shift (r_avg_shift),
        .o_in_ready  (in_ready),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_out       (o_out)
    );

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> o_out.valid)
        else $error("input stalled with no result pending");

    // a memory write never happens while the output register is blocked
    a_write_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (!o_out.valid || o_out.ready))
        else $error("accumulator written while result stalled");

    // a write is always followed by a result on the output
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> o_out.valid)
        else $error("accumulator written without a result");

endmodule

>>> bench/tb_wpea_average_check.sv
// tb_wpea_average_check: watches the item channels and register writes of the averager,
// predicts each result from its own per-point accumulators and frame counters and compares
// depends on wpea_pkg, wpea_in_if and wpea_out_if
module tb_wpea_average_check import wpea_pkg::*; #(
    parameter int POINTS   = POINTS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wpea_in_if                    i_in,
    wpea_out_if                   i_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic             cmd;
        logic             channel;
        logic [POS_W-1:0] position;
        logic [SMP_W-1:0] sample;
        logic             frame_end;
    } t_point_item;

    typedef struct packed {
        logic [SMP_W-1:0] sample_out;
        logic             averaged;
    } t_point_result;

    // predictor state and register copies
    logic [ACC_W-1:0]   point_acc [CHANNELS*POINTS];
    logic [CNT_W-1:0]   frame_cnt [CHANNELS];
    logic [SHIFT_W-1:0] shift_reg;
    logic [CNT_W-1:0]   warmup_reg;
    t_point_result      due_results [$];
    int                 result_num;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_num   = 0;
        foreach (point_acc[i]) point_acc[i] = '0;
    end

    // one line per mismatch, printing capped to keep the log readable
    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_num, what, got, want);
        o_fail_count++;
    endtask

    // update one point's accumulator and the channel's frame count, return the result
    function automatic t_point_result average_point(input t_point_item it);
        t_point_result    res;
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] cnt;
        int               idx;
        res.sample_out = it.sample;
        res.averaged   = 1'b0;
        // clear zeroes every frame count, accumulators stay
        if (it.cmd == CMD_CLEAR) begin
            foreach (frame_cnt[c]) frame_cnt[c] = '0;
            res.sample_out = '0;
            return res;
        end
        if (int'(it.channel) < CHANNELS) begin
            cnt = frame_cnt[it.channel];
            if (int'(it.position) < POINTS) begin
                idx = int'(it.channel) * POINTS + int'(it.position);
                // first frame seeds the point with the sample
                if (cnt == '0)
                    point_acc[idx] = ACC_W'(it.sample);
                acc = point_acc[idx];
                acc = acc - (acc >> shift_reg) + ACC_W'(it.sample);
                point_acc[idx] = acc;
                if (cnt > warmup_reg) begin
                    res.sample_out = SMP_W'(acc >> shift_reg);
                    res.averaged   = 1'b1;
                end
            end
            // frame count saturates
            if (it.frame_end && cnt != COUNT_MAX)
                frame_cnt[it.channel] = cnt + CNT_W'(1);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_point_item   item;
        t_point_result got;
        t_point_result want;
        if (!i_rst_n) begin
            foreach (frame_cnt[c]) frame_cnt[c] = '0;
            shift_reg  = AVG_SHIFT_RST;
            warmup_reg = WARMUP_RST;
            due_results.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_AVG_SHIFT)
                    shift_reg = i_cfg_data[SHIFT_W-1:0];
                else if (i_cfg_index == CFG_WARMUP)
                    warmup_reg = i_cfg_data[CNT_W-1:0];
            end
            // compare an accepted result with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                got.sample_out = i_out.sample_out;
                got.averaged   = i_out.averaged;
                result_num++;
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing pending, sample_out",
                                    int'(got.sample_out), -1);
                end else begin
                    want = due_results.pop_front();
                    if (got.sample_out !== want.sample_out)
                        report_mismatch("sample_out", int'(got.sample_out),
                                        int'(want.sample_out));
                    if (got.averaged !== want.averaged)
                        report_mismatch("averaged", int'(got.averaged),
                                        int'(want.averaged));
                end
            end
            // predict an accepted item
            if (i_in.valid && i_in.ready) begin
                item.cmd       = i_in.cmd;
                item.channel   = i_in.channel;
                item.position  = i_in.position;
                item.sample    = i_in.sample;
                item.frame_end = i_in.frame_end;
                due_results.push_back(average_point(item));
            end
        end
        o_pending <= due_results.size();
    end

endmodule

>>> bench/tb_waveform_point_exponential_averager.sv
// tb_waveform_point_exponential_averager: drives sample items and register settings into
// the averager with random idling on both sides and gives the verdict
// depends on wpea_pkg, wpea_in_if, wpea_out_if, the averager and tb_wpea_average_check
module tb_waveform_point_exponential_averager import wpea_pkg::*; ();

    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int  mismatch_count;
    int  checked_pending;
    int  snd_idle_pct = 8;
    int  rcv_idle_pct = 73;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  long_hold_req = 1'b0;

    // points written so far, so later frames only read seeded entries
    bit               past_first_frame [CHANNELS_DEF];
    bit               seeded [CHANNELS_DEF][POINTS_DEF];
    logic [POS_W-1:0] seeded_list [CHANNELS_DEF][$];

    wpea_in_if  in_ch ();
    wpea_out_if out_ch ();

    waveform_point_exponential_averager uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    tb_wpea_average_check average_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (mismatch_count),
        .o_pending    (checked_pending)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item, hold it until accepted, then track seeded points
    task automatic send_point(input logic cmd, input logic ch, input logic [POS_W-1:0] pos,
                              input logic [SMP_W-1:0] smp, input logic fend);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.channel   <= ch;
        in_ch.position  <= pos;
        in_ch.sample    <= smp;
        in_ch.frame_end <= fend;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (cmd == CMD_CLEAR) begin
            past_first_frame = '{default: 1'b0};
        end else begin
            if (!seeded[ch][pos]) begin
                seeded[ch][pos] = 1'b1;
                seeded_list[ch].push_back(pos);
            end
            if (fend)
                past_first_frame[ch] = 1'b1;
        end
    endtask

    // random item: any point on a first frame, afterwards mostly the first seeded points
    task automatic send_random_point(input int clear_pct, input int fend_pct,
                                     input int ch0_pct, input int full_pct);
        logic             cmd;
        logic             ch;
        logic             fend;
        logic [POS_W-1:0] pos;
        logic [SMP_W-1:0] smp;
        int               n;
        cmd = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_SAMPLE;
        ch  = ($urandom_range(0, 99) < ch0_pct) ? 1'b0 : 1'b1;
        n   = seeded_list[ch].size();
        if (cmd == CMD_CLEAR || !past_first_frame[ch])
            pos = $urandom_range(0, 1) ? POS_W'($urandom) : POS_W'($urandom_range(0, 3));
        else if (n > 2 && $urandom_range(0, 99) < 75)
            pos = seeded_list[ch][$urandom_range(0, 1)];
        else
            pos = seeded_list[ch][$urandom_range(0, n - 1)];
        if ($urandom_range(0, 99) < full_pct)
            smp = '1;
        else if ($urandom_range(0, 99) < 15)
            smp = '0;
        else
            smp = SMP_W'($urandom);
        fend = ($urandom_range(0, 99) < fend_pct);
        send_point(cmd, ch, pos, smp, fend);
    endtask

    // register write, enable left high for a following write
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // drain, set both registers, then stream random items
    task automatic run_phase(input int snd_pct, input int rcv_pct,
                             input logic [SHIFT_W-1:0] shift, input logic [CNT_W-1:0] warmup,
                             input int items, input int clear_pct, input int fend_pct,
                             input int ch0_pct, input int full_pct, input bit pressure);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (checked_pending != 0) @(posedge i_clk);
        write_reg(CFG_AVG_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_WARMUP, CFG_DATA_W'(warmup));
        i_cfg_we <= 1'b0;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        if (pressure)
            long_hold_req <= 1'b1;
        repeat (items) send_random_point(clear_pct, fend_pct, ch0_pct, full_pct);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_AVG_SHIFT;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_SAMPLE;
        in_ch.channel   <= 1'b0;
        in_ch.position  <= '0;
        in_ch.sample    <= '0;
        in_ch.frame_end <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // seed both ends of channel 0 on its first frame
        send_point(CMD_SAMPLE, 1'b0, '0, 8'h00, 1'b0);
        send_point(CMD_SAMPLE, 1'b0, '1, 8'hFF, 1'b1);
        // channel 1 first frame
        send_point(CMD_SAMPLE, 1'b1, '1, 8'hFF, 1'b0);
        send_point(CMD_SAMPLE, 1'b1, '0, 8'h00, 1'b1);
        // warm-up frames pass the sample through
        send_point(CMD_SAMPLE, 1'b0, '0, 8'hFF, 1'b1);
        send_point(CMD_SAMPLE, 1'b0, '1, 8'h00, 1'b1);
        // past warm-up the average comes out on channel 0; channel 1 is still warming up
        send_point(CMD_SAMPLE, 1'b0, '0, 8'h80, 1'b0);
        send_point(CMD_SAMPLE, 1'b0, '1, 8'hFF, 1'b0);
        send_point(CMD_SAMPLE, 1'b1, '1, 8'h01, 1'b1);
        // clear with every other field set, they are ignored
        send_point(CMD_CLEAR, 1'b1, '1, 8'hFF, 1'b1);
        // reseed after the clear with alternating bit patterns, then update one in warm-up
        send_point(CMD_SAMPLE, 1'b0, 10'h2AA, 8'h55, 1'b1);
        send_point(CMD_SAMPLE, 1'b1, 10'h155, 8'hAA, 1'b0);
        send_point(CMD_SAMPLE, 1'b0, 10'h2AA, 8'hAA, 1'b0);

        // slow result side
        run_phase(8, 73, 4'd0, 10'd0, 110, 4, 30, 50, 15, 1'b0);
        run_phase(8, 73, 4'd8, 10'd1, 110, 4, 25, 50, 15, 1'b0);
        // slow item side, shift above eight and warm-up that never ends
        run_phase(73, 8, 4'd15, 10'd3, 110, 2, 20, 50, 15, 1'b0);
        run_phase(73, 8, 4'd4, 10'd1023, 110, 3, 30, 50, 15, 1'b0);
        // full rate, no clears: channel 0 counter saturates, hot points wrap
        run_phase(0, 0, 4'd15, 10'd0, 1150, 0, 100, 95, 60, 1'b0);
        // saturated counter just past warm-up, with a long result hold-off
        run_phase(0, 0, 4'd2, 10'd1022, 80, 0, 40, 60, 15, 1'b1);

        // drain and settle
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (checked_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/wpea_pkg.sv
rtl/core/wpea_in_if.sv
rtl/core/wpea_out_if.sv
rtl/core/wpea_ram.sv
rtl/core/wpea_frame_ctr.sv
rtl/core/wpea_update.sv
rtl/core/waveform_point_exponential_averager.sv
bench/tb_wpea_average_check.sv
bench/tb_waveform_point_exponential_averager.sv
